// ===== rtl/core/banked_register_file_mode_switch_macros.svh =====
// Assertion shorthands for the banked register file checks.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef BANKED_REGISTER_FILE_MODE_SWITCH_MACROS_SVH
`define BANKED_REGISTER_FILE_MODE_SWITCH_MACROS_SVH

// Same-cycle implication
`define BRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/brf_pkg.sv =====
package brf_pkg;

  // Item operations
  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_SWITCH = 2'd2,
    OP_RESET  = 2'd3
  } op_t;

  // Register banks, one per group of modes that share sp, lr and saved status
  typedef enum logic [2:0] {
    BANK_USR  = 3'd0,
    BANK_FAST = 3'd1,
    BANK_IRQ  = 3'd2,
    BANK_SVC  = 3'd3,
    BANK_ABT  = 3'd4,
    BANK_UND  = 3'd5
  } bank_t;

  localparam int NUM_BANKS = 6;
  localparam int NUM_REGS  = 16;
  localparam int NUM_FIQ   = 5;

  // Mode field codes
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // Register indexes
  localparam logic [4:0] IDX_SPSR = 5'd16;
  localparam logic [3:0] REG_R8   = 4'd8;
  localparam logic [3:0] REG_SP   = 4'd13;
  localparam logic [3:0] REG_LR   = 4'd14;
  localparam logic [3:0] REG_PC   = 4'd15;

  // Post-boot values
  localparam logic [31:0] BOOT_SP_USR = 32'h0300_7F00;
  localparam logic [31:0] BOOT_SP_SVC = 32'h0300_7FE0;
  localparam logic [31:0] BOOT_SP_IRQ = 32'h0300_7FA0;
  localparam logic [31:0] BOOT_ENTRY  = 32'h0800_0000;

  // Map a mode field to its bank; unknown codes fall back to user
  function automatic bank_t bank_of(input logic [4:0] mode);
    bank_t b;
    case (mode)
      MODE_FIQ: b = BANK_FAST;
      MODE_IRQ: b = BANK_IRQ;
      MODE_SVC: b = BANK_SVC;
      MODE_ABT: b = BANK_ABT;
      MODE_UND: b = BANK_UND;
      default:  b = BANK_USR;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/banked_register_file_mode_switch.sv =====
// Banked register file with processor mode switching.
// The result beat becomes valid in the cycle after its input beat is accepted.
// Throughput: one item per cycle while the result side is not stalled; all bank swaps are parallel flop moves.
// Reset (rst, synchronous): skip_boot_rom clears, all registers and banks clear, mode
// becomes supervisor; a reset item keeps skip_boot_rom and, if set, seeds boot values and system mode.
module banked_register_file_mode_switch
  import brf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [4:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [4:0]  new_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic [4:0]  current_mode
);

  logic [31:0] regs      [NUM_REGS];
  logic [31:0] bank_sp   [NUM_BANKS];
  logic [31:0] bank_lr   [NUM_BANKS];
  logic [31:0] bank_spsr [NUM_BANKS];
  logic [31:0] fiq_usr   [NUM_FIQ];
  logic [31:0] fiq_fiq   [NUM_FIQ];
  logic [31:0] spsr;
  logic [4:0]  mode;
  logic        skip_boot_rom;

  logic        accept;
  op_t         op;
  bank_t       from_bank;
  bank_t       to_bank;
  logic        bank_change;
  logic        fiq_swap;
  logic        do_boot;
  logic        boot_skip;
  logic [31:0] rd_value;
  logic [4:0]  mode_next;

  // Post-boot value of a visible register
  function automatic logic [31:0] boot_reg(input logic [3:0] r);
    logic [31:0] v;
    case (r)
      REG_SP:         v = BOOT_SP_USR;
      REG_LR, REG_PC: v = BOOT_ENTRY;
      default:        v = '0;
    endcase
    return v;
  endfunction

  // Post-boot stack pointer of a bank
  function automatic logic [31:0] boot_sp(input bank_t b);
    logic [31:0] v;
    case (b)
      BANK_FAST, BANK_ABT, BANK_UND: v = BOOT_SP_USR;
      BANK_SVC:                      v = BOOT_SP_SVC;
      BANK_IRQ:                      v = BOOT_SP_IRQ;
      default:                       v = '0;
    endcase
    return v;
  endfunction

  // Take a new beat whenever the result register is free or draining
  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(operation);

  assign from_bank   = bank_of(mode);
  assign to_bank     = bank_of(new_mode);
  assign bank_change = (from_bank != to_bank);
  assign fiq_swap    = bank_change && (from_bank == BANK_FAST || to_bank == BANK_FAST);

  assign do_boot   = rst || (accept && op == OP_RESET);
  assign boot_skip = !rst && skip_boot_rom;

  // Decode the read and the mode after this item
  always_comb begin
    rd_value = '0;
    if (op == OP_READ) begin
      if (!reg_index[4]) begin
        rd_value = regs[reg_index[3:0]];
      end else if (reg_index == IDX_SPSR) begin
        rd_value = spsr;
      end
    end
    case (op)
      OP_SWITCH: mode_next = new_mode;
      OP_RESET:  mode_next = skip_boot_rom ? MODE_SYS : MODE_SVC;
      default:   mode_next = mode;
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_boot_rom <= 1'b0;
    end else if (cfg_wr_en) begin
      skip_boot_rom <= cfg_wr_data;
    end
  end

  // Register file, banks and mode
  always_ff @(posedge clk) begin
    if (do_boot) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[4'(i)] <= boot_skip ? boot_reg(4'(i)) : '0;
      end
      for (int b = 0; b < NUM_BANKS; b++) begin
        bank_sp[3'(b)]   <= boot_skip ? boot_sp(bank_t'(3'(b))) : '0;
        bank_lr[3'(b)]   <= '0;
        bank_spsr[3'(b)] <= '0;
      end
      for (int i = 0; i < NUM_FIQ; i++) begin
        fiq_usr[3'(i)] <= '0;
        fiq_fiq[3'(i)] <= '0;
      end
      spsr <= '0;
      mode <= boot_skip ? MODE_SYS : MODE_SVC;
    end else if (accept) begin
      case (op)
        OP_WRITE: begin
          if (!reg_index[4]) begin
            regs[reg_index[3:0]] <= write_data;
          end else if (reg_index == IDX_SPSR) begin
            spsr <= write_data;
          end
        end
        OP_SWITCH: begin
          // Store sp, lr, saved status to the old bank and load the new one
          if (bank_change) begin
            bank_sp[from_bank]   <= regs[REG_SP];
            bank_lr[from_bank]   <= regs[REG_LR];
            bank_spsr[from_bank] <= spsr;
            regs[REG_SP]         <= bank_sp[to_bank];
            regs[REG_LR]         <= bank_lr[to_bank];
            spsr                 <= bank_spsr[to_bank];
          end
          // Swap r8..r12 when entering or leaving FIQ
          if (fiq_swap) begin
            for (int i = 0; i < NUM_FIQ; i++) begin
              if (from_bank == BANK_FAST) begin
                fiq_fiq[3'(i)] <= regs[REG_R8 + 4'(i)];
              end else begin
                fiq_usr[3'(i)] <= regs[REG_R8 + 4'(i)];
              end
              regs[REG_R8 + 4'(i)] <= (to_bank == BANK_FAST) ? fiq_fiq[3'(i)]
                                                             : fiq_usr[3'(i)];
            end
          end
          mode <= mode_next;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data    <= rd_value;
      current_mode <= mode_next;
    end
  end

endmodule

// ===== rtl/core/brf_checker.sv =====
`include "banked_register_file_mode_switch_macros.svh"

module brf_checker
  import brf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  operation,
  input logic [4:0]  new_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] read_data,
  input logic [4:0]  current_mode
);

  logic accept;
  assign accept = in_valid && in_ready;

  // A stalled result beat holds
  `BRF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(current_mode), "result changed while stalled")

  // Anything but a read returns zero data in the cycle after it is accepted
  `BRF_ASSERT_NEXT(a_nonread_zero, accept && operation != OP_READ, out_valid && read_data == '0, "non-read item returned data")

  // A switch reports the requested mode
  `BRF_ASSERT_NEXT(a_switch_mode, accept && operation == OP_SWITCH, out_valid && current_mode == $past(new_mode), "switch did not take the new mode")

  // A reset item lands in supervisor or system mode
  `BRF_ASSERT_NEXT(a_reset_mode, accept && operation == OP_RESET, current_mode == MODE_SVC || current_mode == MODE_SYS, "reset gave an unexpected mode")

  // An empty result register never blocks the input once out of reset
  `BRF_ASSERT_NOW(a_ready_empty, !rst && !out_valid, in_ready, "input stalled with empty output")

endmodule

bind banked_register_file_mode_switch brf_checker u_brf_checker (.*);

// ===== sim/banked_regfile_checker.sv =====
module banked_regfile_checker
  import brf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [4:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [4:0]  new_mode,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] read_data,
  input  logic [4:0]  current_mode,
  output int          mismatches,
  output int          backlog,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] STATUS_AT_RESET = 32'h0000_00D3;
  localparam logic [31:0] STATUS_BOOTED   = 32'h0000_005F;

  typedef struct packed {
    logic [31:0] data;
    logic [4:0]  mode;
  } beat_t;

  // Shadow copy of the register file
  logic [31:0] gpr [NUM_REGS];
  logic [31:0] sp_bank [NUM_BANKS];
  logic [31:0] lr_bank [NUM_BANKS];
  logic [31:0] spsr_bank [NUM_BANKS];
  // r8..r12 parked while the other side is live: [0] non-FIQ, [1] FIQ
  logic [31:0] fiq_shadow [2][NUM_FIQ];
  logic [31:0] cpsr;
  logic [31:0] spsr;
  logic        boot_skip;

  beat_t expected_beats [$];
  int    err_count;
  int    beat_count;

  // Group mode codes by the bank they share; anything unlisted uses the user bank
  function automatic bank_t bank_for_mode(input logic [4:0] m);
    if (m == MODE_FIQ) return BANK_FAST;
    else if (m == MODE_IRQ) return BANK_IRQ;
    else if (m == MODE_SVC) return BANK_SVC;
    else if (m == MODE_ABT) return BANK_ABT;
    else if (m == MODE_UND) return BANK_UND;
    return BANK_USR;
  endfunction

  // Clear everything, then seed the post-boot values if requested
  task automatic load_reset_state();
    foreach (gpr[i]) gpr[i] = '0;
    foreach (sp_bank[b]) begin
      sp_bank[b]   = '0;
      lr_bank[b]   = '0;
      spsr_bank[b] = '0;
    end
    foreach (fiq_shadow[s, i]) fiq_shadow[s][i] = '0;
    spsr = '0;
    if (boot_skip) begin
      gpr[REG_SP]        = BOOT_SP_USR;
      gpr[REG_LR]        = BOOT_ENTRY;
      gpr[REG_PC]        = BOOT_ENTRY;
      cpsr               = STATUS_BOOTED;
      sp_bank[BANK_FAST] = BOOT_SP_USR;
      sp_bank[BANK_ABT]  = BOOT_SP_USR;
      sp_bank[BANK_UND]  = BOOT_SP_USR;
      sp_bank[BANK_SVC]  = BOOT_SP_SVC;
      sp_bank[BANK_IRQ]  = BOOT_SP_IRQ;
    end else begin
      cpsr = STATUS_AT_RESET;
    end
  endtask

  // Swap sp, lr and saved status on a bank change; swap r8..r12 across FIQ
  task automatic change_mode(input logic [4:0] m);
    bank_t from;
    bank_t to;
    from = bank_for_mode(cpsr[4:0]);
    to   = bank_for_mode(m);
    if (from != to) begin
      sp_bank[from]   = gpr[REG_SP];
      lr_bank[from]   = gpr[REG_LR];
      spsr_bank[from] = spsr;
      gpr[REG_SP]     = sp_bank[to];
      gpr[REG_LR]     = lr_bank[to];
      spsr            = spsr_bank[to];
      if (from == BANK_FAST || to == BANK_FAST) begin
        for (int i = 0; i < NUM_FIQ; i++)
          fiq_shadow[from == BANK_FAST][3'(i)] = gpr[REG_R8 + 4'(i)];
        for (int i = 0; i < NUM_FIQ; i++)
          gpr[REG_R8 + 4'(i)] = fiq_shadow[to == BANK_FAST][3'(i)];
      end
    end
    cpsr[4:0] = m;
  endtask

  // Advance the shadow state by one access and work out its result beat
  task automatic apply_access(input logic [1:0] op, input logic [4:0] idx,
                              input logic [31:0] data, input logic [4:0] mode,
                              output beat_t res);
    res.data = '0;
    case (op)
      OP_READ: begin
        if (idx < NUM_REGS) res.data = gpr[idx[3:0]];
        else if (idx == IDX_SPSR) res.data = spsr;
      end
      OP_WRITE: begin
        if (idx < NUM_REGS) gpr[idx[3:0]] = data;
        else if (idx == IDX_SPSR) spsr = data;
      end
      OP_SWITCH: change_mode(mode);
      default: load_reset_state();
    endcase
    res.mode = cpsr[4:0];
  endtask

  // Match a result beat against the oldest expectation
  task automatic compare_beat(input beat_t got);
    beat_t want;
    beat_count++;
    if (expected_beats.size() == 0) begin
      err_count++;
      $display("%0t ns: unexpected result beat, read_data %h current_mode %h",
               $time, got.data, got.mode);
    end else begin
      want = expected_beats.pop_front();
      if (got.data !== want.data) begin
        err_count++;
        $display("%0t ns: read_data expected %h actual %h", $time, want.data, got.data);
      end
      if (got.mode !== want.mode) begin
        err_count++;
        $display("%0t ns: current_mode expected %h actual %h", $time, want.mode, got.mode);
      end
    end
  endtask

  always @(posedge clk) begin : track
    beat_t res;
    if (rst) begin
      boot_skip = 1'b0;
      load_reset_state();
      expected_beats.delete();
    end else begin
      if (cfg_wr_en) boot_skip = cfg_wr_data;
      if (out_valid && out_ready) compare_beat(beat_t'({read_data, current_mode}));
      if (in_valid && in_ready) begin
        apply_access(operation, reg_index, write_data, new_mode, res);
        expected_beats.push_back(res);
      end
    end
    mismatches <= err_count;
    backlog    <= expected_beats.size();
    checked    <= beat_count;
  end

endmodule

// ===== sim/tb_banked_register_file_mode_switch.sv =====
module tb_banked_register_file_mode_switch;
  timeunit 1ns;
  timeprecision 1ps;
  import brf_pkg::*;

  localparam int LATENCY     = 1;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 96;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 225;

  localparam logic [4:0] MODE_USER = 5'h10;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid    = 1'b0;
  op_t         operation   = OP_READ;
  logic [4:0]  reg_index   = '0;
  logic [31:0] write_data  = '0;
  logic [4:0]  new_mode    = '0;
  logic        out_ready   = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] read_data;
  logic [4:0]  current_mode;

  int mismatches;
  int backlog;
  int checked;
  int op_seen [4];
  int watch_count;
  bit hold_request;
  bit hold_active;

  logic [4:0] legal_modes [7] = '{MODE_USER, MODE_FIQ, MODE_IRQ, MODE_SVC,
                                  MODE_ABT, MODE_UND, MODE_SYS};

  banked_register_file_mode_switch dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .new_mode     (new_mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .current_mode (current_mode)
  );

  banked_regfile_checker regfile_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .new_mode     (new_mode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .current_mode (current_mode),
    .mismatches   (mismatches),
    .backlog      (backlog),
    .checked      (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one access and hold it until the beat is taken; valid stays up
  task automatic issue_access(input op_t op, input logic [4:0] idx,
                              input logic [31:0] data, input logic [4:0] mode);
    in_valid   <= 1'b1;
    operation  <= op;
    reg_index  <= idx;
    write_data <= data;
    new_mode   <= mode;
    do @(posedge clk); while (!in_ready);
    op_seen[int'(op)]++;
  endtask

  // Drop valid and keep it low for the pause given by n (n is at least one)
  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and wait until every expected beat has come back
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_boot_skip(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly legal modes and banked registers, some stray codes and indexes
  task automatic issue_random_access();
    op_t         op;
    logic [4:0]  idx;
    logic [4:0]  mode;
    logic [31:0] data;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 36) op = OP_READ;
    else if (pick < 70) op = OP_WRITE;
    else if (pick < 99) op = OP_SWITCH;
    else op = OP_RESET;
    case ($urandom_range(0, 9))
      0:       idx = 5'($urandom_range(17, 31));
      1, 2, 3: idx = 5'($urandom_range(0, 7));
      default: idx = 5'($urandom_range(8, 16));
    endcase
    case ($urandom_range(0, 7))
      0:       data = '0;
      1:       data = '1;
      default: data = $urandom();
    endcase
    mode = ($urandom_range(0, 6) == 0) ? 5'($urandom()) : legal_modes[$urandom_range(0, 6)];
    issue_access(op, idx, data, mode);
  endtask

  // Stimulus
  initial begin
    int n;
    int burst;
    int gap;
    int drain_at;
    bit no_gaps;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, stray indexes, FIQ entry and exit, every bank
    issue_access(OP_READ,   5'd0,     '0,            '0);
    issue_access(OP_WRITE,  5'd0,     32'hFFFF_FFFF, '0);
    issue_access(OP_READ,   5'd0,     '0,            '0);
    issue_access(OP_WRITE,  5'd15,    32'h0000_0000, '0);
    issue_access(OP_WRITE,  IDX_SPSR, 32'hFFFF_FFFF, '0);
    issue_access(OP_READ,   IDX_SPSR, '0,            '0);
    issue_access(OP_WRITE,  5'd31,    32'hA5A5_A5A5, '0);
    issue_access(OP_READ,   5'd31,    '0,            '0);
    issue_access(OP_READ,   5'd17,    '0,            '0);
    issue_access(OP_WRITE,  5'd8,     32'h1234_5678, '0);
    issue_access(OP_WRITE,  5'd13,    32'hDEAD_BEEF, '0);
    issue_access(OP_SWITCH, '0,       '0,            MODE_FIQ);
    issue_access(OP_READ,   5'd8,     '0,            '0);
    issue_access(OP_WRITE,  5'd12,    32'hFFFF_0000, '0);
    issue_access(OP_SWITCH, '0,       '0,            MODE_USER);
    issue_access(OP_READ,   5'd8,     '0,            '0);
    issue_access(OP_SWITCH, '0,       '0,            MODE_SYS);
    issue_access(OP_WRITE,  IDX_SPSR, 32'h0000_005A, '0);
    issue_access(OP_READ,   IDX_SPSR, '0,            '0);
    issue_access(OP_SWITCH, '0,       '0,            5'h00);
    issue_access(OP_SWITCH, '0,       '0,            MODE_UND);
    issue_access(OP_SWITCH, '0,       '0,            MODE_ABT);
    issue_access(OP_SWITCH, '0,       '0,            MODE_IRQ);
    issue_access(OP_SWITCH, '0,       '0,            MODE_SVC);
    issue_access(OP_READ,   5'd13,    '0,            '0);
    issue_access(OP_RESET,  '0,       '0,            '0);
    wait_until_drained();

    // Random phases, alternating the boot setting and re-applying reset each time
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_boot_skip(p % 2 == 0);
      issue_access(OP_RESET, 5'($urandom()), $urandom(), 5'($urandom()));
      no_gaps = (p == 2);

      // Stall the result side for a long stretch while accesses keep coming
      if (p == 1) begin
        pause_sender(1);
        hold_request = 1'b1;
        while (!hold_active) @(posedge clk);
        repeat (24) issue_random_access();
      end

      drain_at = $urandom_range(40, PHASE_ITEMS - 40);
      n = 0;
      while (n < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && n < PHASE_ITEMS; k++) begin
          issue_random_access();
          n++;
          if (n == drain_at) wait_until_drained();
        end
        gap = $urandom_range(0, 10);
        if (gap > 0 && !no_gaps) pause_sender(gap);
      end
      wait_until_drained();
    end

    $display("Covered %0d accesses: %0d reads, %0d writes, %0d mode switches, %0d resets",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("%0d boot settings alternated, %0d result beats checked, %0d mismatches",
             NUM_PHASES, checked, mismatches);
    if (mismatches == 0 && backlog == 0) begin
      $display("banked_register_file_mode_switch verification clean");
    end else begin
      $display("banked_register_file_mode_switch verification failed");
    end
    $finish;
  end

  // Result side: ready stalls on its own pattern, plus one long hold on request
  initial begin
    int style;
    int span;
    int period;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        out_ready   <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active  = 1'b0;
      end else begin
        style  = $urandom_range(0, 3);
        span   = $urandom_range(4, 40);
        period = $urandom_range(2, 6);
        for (int k = 0; k < span; k++) begin
          case (style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 99) < 70);
            2:       out_ready <= (k % period != 0);
            default: out_ready <= ($urandom_range(0, 99) < 15);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      watch_count <= 0;
    end else begin
      watch_count <= watch_count + 1;
    end
    if (watch_count >= STALL_LIMIT) begin
      $display("%0t ns: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("banked_register_file_mode_switch verification failed");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/brf_pkg.sv
rtl/core/banked_register_file_mode_switch.sv
rtl/core/brf_checker.sv
sim/banked_regfile_checker.sv
sim/tb_banked_register_file_mode_switch.sv
